// ----- hdl/tlge_pkg.sv -----
// Shared constants and types for the toroidal Life engine.
package tlge_pkg;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MIN_WIDTH      = 16;
    localparam int MIN_HEIGHT     = 2;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RUN     = 2'd2;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] STAY_COUNT  = 4'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;
endpackage

// ----- hdl/tlge_row_cell.sv -----
// One row of the grid: holds its cells and computes their next generation.
module tlge_row_cell #(
    parameter int MAX_WIDTH = tlge_pkg::MAX_WIDTH_DEF,
    parameter int CI        = $clog2(MAX_WIDTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 wr_en,
    input  logic [CI-1:0]        wr_col,
    input  logic                 wr_val,
    input  logic [MAX_WIDTH-1:0] mask,
    input  logic [CI-1:0]        last_col,
    input  logic [MAX_WIDTH-1:0] up_row,
    input  logic [MAX_WIDTH-1:0] down_row,
    output logic [MAX_WIDTH-1:0] row_reg
);
    logic [MAX_WIDTH-1:0] row_next;
    logic [MAX_WIDTH-1:0] live;
    logic [MAX_WIDTH-1:0] mu, mm, md;

    assign mu = up_row & mask;
    assign mm = row_reg & mask;
    assign md = down_row & mask;

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
        localparam int CL = (c == 0) ? MAX_WIDTH - 1 : c - 1;
        localparam int CR = (c == MAX_WIDTH - 1) ? 0 : c + 1;
        logic [2:0] wsel;
        logic [2:0] esel;
        logic [3:0] cnt;
        assign wsel = (c == 0) ? {mu[last_col], mm[last_col], md[last_col]}
                               : {mu[CL], mm[CL], md[CL]};
        assign esel = (CI'(c) == last_col) ? {mu[0], mm[0], md[0]}
                                           : {mu[CR], mm[CR], md[CR]};
        assign cnt = 4'(wsel[2]) + 4'(wsel[1]) + 4'(wsel[0])
                   + 4'(esel[2]) + 4'(esel[1]) + 4'(esel[0])
                   + 4'(mu[c]) + 4'(md[c]);
        assign live[c] = (cnt == tlge_pkg::BIRTH_COUNT)
                      || ((cnt == tlge_pkg::STAY_COUNT) && mm[c]);
    end

    always_comb begin
        row_next = row_reg;
        if (advance) begin
            row_next = (row_reg & ~mask) | (live & mask);
        end else if (wr_en) begin
            row_next[wr_col] = wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end
endmodule

// ----- hdl/toroidal_life_generation_engine_unit.sv -----
// Top level of the toroidal Life engine: request control, config and row chain.
//
// Requests enter on s_* (valid/ready) and results leave on m_* (valid/ready),
// one result per request. Write and read requests give their result one cycle
// after acceptance and may be accepted every cycle while results are taken.
// A run request advances the whole grid one generation per cycle, every row
// cell updating from its neighbors at once, so it takes generation_count
// cycles (one for zero) before its result appears; no request is accepted
// meanwhile. Action 3 gives a result with op_done 0.
// The APB port holds grid_width (address 0) and grid_height (address 4);
// write them only while idle. Out-of-range sizes saturate to 16..MAX_WIDTH
// and 2..MAX_HEIGHT.
// Reset clears every cell to dead and sets both sizes to 64; it is done in
// the reset cycle itself. When the receiver stalls, the result is held in the
// output register and no new request is accepted until it is taken.
module toroidal_life_generation_engine_unit #(
    parameter int MAX_WIDTH  = tlge_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tlge_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_row_index,
    input  logic [5:0]  s_col_index,
    input  logic        s_cell_in,
    input  logic [15:0] s_generation_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cell_out,
    output logic        m_op_done
);
    localparam int CI  = $clog2(MAX_WIDTH);
    localparam int RI  = $clog2(MAX_HEIGHT);
    localparam int WBW = $clog2(MAX_WIDTH + 1);
    localparam int HBW = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = (WBW > 7) ? WBW : 7;
    localparam int HW  = (HBW > 7) ? HBW : 7;

    logic [6:0] grid_width_reg, grid_height_reg;
    logic [CW-1:0] eff_w, col_ext;
    logic [HW-1:0] eff_h, row_ext;
    logic [CI-1:0] last_col;
    logic [RI-1:0] last_row;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];

    tlge_pkg::state_t state_reg, state_next;
    logic [15:0] gens_reg, gens_next;
    logic m_valid_reg, m_valid_next;
    logic m_cell_reg, m_cell_next;
    logic m_done_reg, m_done_next;
    logic accept, in_grid, advance;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {25'd0, grid_height_reg} : {25'd0, grid_width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tlge_pkg::REG_HEIGHT) begin
                grid_height_reg <= pwdata[6:0];
            end else begin
                grid_width_reg <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (CW'(grid_width_reg) < CW'(tlge_pkg::MIN_WIDTH)) begin
            eff_w = CW'(tlge_pkg::MIN_WIDTH);
        end else if (CW'(grid_width_reg) > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(grid_width_reg);
        end
        if (HW'(grid_height_reg) < HW'(tlge_pkg::MIN_HEIGHT)) begin
            eff_h = HW'(tlge_pkg::MIN_HEIGHT);
        end else if (HW'(grid_height_reg) > HW'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(grid_height_reg);
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            mask[c] = CW'(c) < eff_w;
        end
    end

    assign last_col = CI'(eff_w - CW'(1));
    assign last_row = RI'(eff_h - HW'(1));
    assign col_ext  = CW'(s_col_index);
    assign row_ext  = HW'(s_row_index);
    assign in_grid  = (col_ext < eff_w) && (row_ext < eff_h);
    assign accept   = s_valid && s_ready;
    assign advance  = state_reg == tlge_pkg::ST_RUN;
    assign s_ready  = (state_reg == tlge_pkg::ST_IDLE) && (!m_valid_reg || m_ready);

    for (genvar r = 0; r < MAX_HEIGHT; r++) begin : g_row
        localparam int RD = (r == MAX_HEIGHT - 1) ? 0 : r + 1;
        logic [MAX_WIDTH-1:0] up_row, down_row;
        logic wr_en;
        assign up_row   = (r == 0) ? rows[last_row] : rows[(r == 0) ? 0 : r - 1];
        assign down_row = (RI'(r) == last_row) ? rows[0] : rows[RD];
        assign wr_en    = accept && (s_action == tlge_pkg::ACT_WRITE) && in_grid
                       && (row_ext == HW'(r));
        tlge_row_cell #(
            .MAX_WIDTH(MAX_WIDTH),
            .CI(CI)
        ) u_cell (
            .aclk(aclk),
            .aresetn(aresetn),
            .advance(advance && (HW'(r) < eff_h)),
            .wr_en(wr_en),
            .wr_col(CI'(col_ext)),
            .wr_val(s_cell_in),
            .mask(mask),
            .last_col(last_col),
            .up_row(up_row),
            .down_row(down_row),
            .row_reg(rows[r])
        );
    end

    always_comb begin
        state_next   = state_reg;
        gens_next    = gens_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_cell_next  = m_cell_reg;
        m_done_next  = m_done_reg;
        unique case (state_reg)
            tlge_pkg::ST_IDLE: begin
                if (accept) begin
                    m_cell_next = 1'b0;
                    m_done_next = 1'b1;
                    unique case (s_action)
                        tlge_pkg::ACT_WRITE: m_valid_next = 1'b1;
                        tlge_pkg::ACT_READ: begin
                            m_valid_next = 1'b1;
                            m_cell_next  = in_grid
                                && rows[RI'(row_ext)][CI'(col_ext)];
                        end
                        tlge_pkg::ACT_RUN: begin
                            if (s_generation_count == 16'd0) begin
                                m_valid_next = 1'b1;
                            end else begin
                                gens_next  = s_generation_count;
                                state_next = tlge_pkg::ST_RUN;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_done_next  = 1'b0;
                        end
                    endcase
                end
            end
            tlge_pkg::ST_RUN: begin
                gens_next = gens_reg - 16'd1;
                if (gens_reg == 16'd1) begin
                    state_next   = tlge_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                    m_cell_next  = 1'b0;
                    m_done_next  = 1'b1;
                end
            end
            default: state_next = tlge_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tlge_pkg::ST_IDLE;
            gens_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gens_reg    <= gens_next;
            m_valid_reg <= m_valid_next;
        end
        m_cell_reg <= m_cell_next;
        m_done_reg <= m_done_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_reg;
    assign m_op_done  = m_done_reg;
endmodule
